### design/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg: terminal line discipline shared definitions
// character codes, result kinds, register indexes and reset values used by
// the line discipline and its checker
// ----------------------------------------------------------------------------
package tld_pkg;

	// default depth of the line store
	localparam int LINE_DEPTH_DEF = 32;

	// fixed field widths
	localparam int CHAR_W  = 8;
	localparam int LEN_W   = 6;
	localparam int CFG_IDX_W = 3;

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_BS = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_SP = 8'h20;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_DATA = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INPUT_FLAGS  = 3'd0,
		CFG_OUTPUT_FLAGS = 3'd1,
		CFG_LOCAL_FLAGS  = 3'd2,
		CFG_ERASE_CHAR   = 3'd3,
		CFG_KILL_CHAR    = 3'd4,
		CFG_EOF_CHAR     = 3'd5,
		CFG_READ_LIMIT   = 3'd6
	} cfg_idx_t;

	// register reset values
	localparam logic [2:0]        IFLAG_RST      = 3'd0;
	localparam logic [3:0]        OFLAG_RST      = 4'd3;
	localparam logic [4:0]        LFLAG_RST      = 5'd15;
	localparam logic [CHAR_W-1:0] ERASE_RST      = 8'h7F;
	localparam logic [CHAR_W-1:0] KILL_RST       = 8'h15;
	localparam logic [CHAR_W-1:0] EOF_RST        = 8'h04;
	localparam logic [LEN_W-1:0]  READ_LIMIT_RST = 6'd32;

endpackage

### design/tld_ram.sv
// ----------------------------------------------------------------------------
// tld_ram: generic single-port-write, single-port-read memory
// one write and one registered read per cycle, contents not reset
// ----------------------------------------------------------------------------
module tld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/terminal_line_discipline.sv
// ----------------------------------------------------------------------------
// terminal_line_discipline: canonical terminal line discipline
// sequence: the character is latched, then its echo bytes and next step are
//   planned in S_PLAN; its results then go into the output register in order:
//   E echo bytes (0 to 4), then a raw byte, or N line bytes and an end marker,
//   or nothing more; each line byte is read through the registered read port
//   in S_RD and loaded from it in S_DATA
// the character input is stalled from its transfer until its last result is
//   loaded into the output register, or its plan is made if it has no result
// reset: flags, control characters and the read limit take their defaults,
//   the line is emptied; the line store itself is not cleared
// ----------------------------------------------------------------------------
module terminal_line_discipline #(
	parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// character input
	input  logic                          rx_valid,
	output logic                          rx_stall,
	input  logic [tld_pkg::CHAR_W-1:0]    rx_char,
	// results
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [1:0]                    kind,
	output logic [tld_pkg::CHAR_W-1:0]    data_byte,
	output logic [tld_pkg::LEN_W-1:0]     line_length,
	output logic                          last,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tld_pkg::CHAR_W-1:0]    cfg_data
);

	import tld_pkg::*;

	// fill count holds 0..LINE_DEPTH, store address 0..LINE_DEPTH-1
	localparam int FW = $clog2(LINE_DEPTH + 1);
	localparam int AW = $clog2(LINE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PLAN,
		S_ECHO,
		S_RAW,
		S_RD,
		S_DATA,
		S_MARK
	} state_t;

	// what follows the echo bytes
	typedef enum logic [1:0] {
		M_NONE,
		M_RAW,
		M_LINE
	} mode_t;

	// configuration registers
	logic [2:0]        iflag_q;
	logic [3:0]        oflag_q;
	logic [4:0]        lflag_q;
	logic [CHAR_W-1:0] erase_q;
	logic [CHAR_W-1:0] kill_q;
	logic [CHAR_W-1:0] eof_q;
	logic [LEN_W-1:0]  limit_q;

	// sequencer and plan registers
	state_t               state_q;
	logic [CHAR_W-1:0]    char_q;
	logic [3:0][CHAR_W-1:0] echo_q;
	logic [2:0]           echo_cnt_q;
	logic [1:0]           echo_idx_q;
	mode_t                mode_q;
	logic [CHAR_W-1:0]    raw_q;
	logic [FW-1:0]        fill_q;
	logic [FW-1:0]        n_q;
	logic [FW-1:0]        idx_q;

	// output register
	logic                 res_valid_q;
	logic [1:0]           kind_q;
	logic [CHAR_W-1:0]    byte_q;
	logic [LEN_W-1:0]     len_q;
	logic                 last_q;

	// plan, worked out from the latched character
	logic                   post, canon, do_echo, pre_cr, skip, prt;
	logic [CHAR_W-1:0]      ec;
	logic [2:0][CHAR_W-1:0] body;
	logic [1:0]             body_len;
	logic [3:0][CHAR_W-1:0] echo_d;
	logic [2:0]             echo_cnt_d;
	logic [CHAR_W-1:0]      mc;
	logic                   ign;
	logic [FW-1:0]          fill_d;
	logic                   store;
	logic                   deliver;
	logic [FW-1:0]          n_d;
	mode_t                  mode_d;
	state_t                 after_plan, after_echo;

	// output slot may be loaded this cycle
	logic                   slot_free;
	logic                   rd_en;
	logic [CHAR_W-1:0]      rd_data;

	assign slot_free = !res_valid_q || !res_stall;
	assign rx_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// ---------------------------------------------------------------- echo
	always_comb begin
		post    = oflag_q[0];
		canon   = lflag_q[0];
		do_echo = lflag_q[1] || ((char_q == CHAR_NL) && lflag_q[4]);
		ec      = char_q;
		prt     = !char_q[7] && (char_q[6:5] != 2'd0);
		pre_cr  = 1'b0;
		skip    = 1'b0;
		// output post-processing
		if (post) begin
			if ((char_q == CHAR_NL) && oflag_q[1]) begin
				pre_cr = 1'b1;
				prt    = 1'b1;
			end else if ((char_q == CHAR_CR) && oflag_q[3]) begin
				skip = 1'b1;
			end else if ((char_q == CHAR_CR) && oflag_q[2]) begin
				ec  = CHAR_NL;
				prt = 1'b1;
			end
		end
		// erase echoes as backspace-space-backspace, kill as newline (then carriage return when output flags 0 and 1 are set)
		body = '{CHAR_BS, CHAR_SP, CHAR_BS};
		if (canon && lflag_q[2] && (ec == erase_q)) begin
			body_len = 2'd3;
		end else if (canon && lflag_q[3] && (ec == kill_q)) begin
			body[2]  = CHAR_NL;
			body[1]  = CHAR_CR;
			body_len = (post && oflag_q[1]) ? 2'd2 : 2'd1;
		end else if (prt) begin
			body[2]  = ec;
			body_len = 2'd1;
		end else begin
			body_len = 2'd0;
		end
		// entry 0 of the echo list goes out first
		if (pre_cr) begin
			echo_d     = {body[0], body[1], body[2], CHAR_CR};
			echo_cnt_d = 3'd1 + {1'b0, body_len};
		end else begin
			echo_d     = {CHAR_SP, body[0], body[1], body[2]};
			echo_cnt_d = {1'b0, body_len};
		end
		if (skip || !do_echo) begin
			echo_cnt_d = 3'd0;
		end
	end

	// ---------------------------------------------------- input map and edit
	always_comb begin
		mc  = char_q;
		ign = 1'b0;
		if (char_q == CHAR_CR) begin
			if (iflag_q[0]) begin
				mc = CHAR_NL;
			end else if (iflag_q[1]) begin
				ign = 1'b1;
			end
		end
		if ((mc == CHAR_NL) && iflag_q[2]) begin
			mc = CHAR_CR;
		end

		fill_d  = fill_q;
		store   = 1'b0;
		deliver = 1'b0;
		n_d     = fill_q;
		mode_d  = M_NONE;
		if (!ign && lflag_q[0]) begin
			if (mc == erase_q) begin
				// erase on an empty line is ignored
				if (fill_q != '0) begin
					fill_d = fill_q - FW'(1);
				end
			end else if (mc == kill_q) begin
				fill_d = '0;
			end else if (mc != eof_q) begin
				if (fill_q < FW'(LINE_DEPTH)) begin
					store  = 1'b1;
					fill_d = fill_q + FW'(1);
				end
			end
			deliver = (mc == CHAR_NL) || (mc == eof_q) || (fill_d >= FW'(LINE_DEPTH));
			if ({1'b0, limit_q} < 7'(fill_d)) begin
				n_d = FW'(limit_q);
			end else begin
				n_d = fill_d;
			end
			if (deliver) begin
				mode_d = M_LINE;
				fill_d = '0;
			end
		end else if (!ign) begin
			mode_d = M_RAW;
		end
	end

	// where the sequencer goes once the echo bytes are out
	always_comb begin
		case (mode_d)
			M_RAW:   after_plan = S_RAW;
			M_LINE:  after_plan = (n_d == '0) ? S_MARK : S_RD;
			default: after_plan = S_IDLE;
		endcase
		case (mode_q)
			M_RAW:   after_echo = S_RAW;
			M_LINE:  after_echo = (n_q == '0) ? S_MARK : S_RD;
			default: after_echo = S_IDLE;
		endcase
	end

	// ----------------------------------------------------------- line store
	assign rd_en = (state_q == S_RD);

	tld_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   ((state_q == S_PLAN) && store),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (mc),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// ------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iflag_q <= IFLAG_RST;
			oflag_q <= OFLAG_RST;
			lflag_q <= LFLAG_RST;
			erase_q <= ERASE_RST;
			kill_q  <= KILL_RST;
			eof_q   <= EOF_RST;
			limit_q <= READ_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INPUT_FLAGS:  iflag_q <= cfg_data[2:0];
				CFG_OUTPUT_FLAGS: oflag_q <= cfg_data[3:0];
				CFG_LOCAL_FLAGS:  lflag_q <= cfg_data[4:0];
				CFG_ERASE_CHAR:   erase_q <= cfg_data;
				CFG_KILL_CHAR:    kill_q  <= cfg_data;
				CFG_EOF_CHAR:     eof_q   <= cfg_data;
				CFG_READ_LIMIT:   limit_q <= cfg_data[LEN_W-1:0];
				default:          ;  // writes beyond the list are dropped
			endcase
		end
	end

	// ----------------------------------------------------------- sequencer
	// one result per transfer slot: echo bytes, then a raw byte or the line
	// bytes and the end marker, or nothing after the echo bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (rx_valid) begin
						char_q  <= rx_char;
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					echo_q     <= echo_d;
					echo_cnt_q <= echo_cnt_d;
					echo_idx_q <= '0;
					mode_q     <= mode_d;
					raw_q      <= mc;
					n_q        <= n_d;
					idx_q      <= '0;
					fill_q     <= fill_d;
					state_q    <= (echo_cnt_d != 3'd0) ? S_ECHO : after_plan;
				end
				S_ECHO: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						kind_q      <= KIND_ECHO;
						byte_q      <= echo_q[echo_idx_q];
						len_q       <= '0;
						last_q      <= ({1'b0, echo_idx_q} == echo_cnt_q - 3'd1) &&
							(mode_q == M_NONE);
						echo_idx_q  <= echo_idx_q + 2'd1;
						if ({1'b0, echo_idx_q} == echo_cnt_q - 3'd1) begin
							state_q <= after_echo;
						end
					end
				end
				S_RAW: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						kind_q      <= KIND_DATA;
						byte_q      <= raw_q;
						len_q       <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_RD: begin
					// read issued, data lands next cycle
					state_q <= S_DATA;
				end
				S_DATA: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						kind_q      <= KIND_DATA;
						byte_q      <= rd_data;
						len_q       <= '0;
						last_q      <= 1'b0;
						idx_q       <= idx_q + FW'(1);
						state_q     <= ((idx_q + FW'(1)) == n_q) ? S_MARK : S_RD;
					end
				end
				S_MARK: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						kind_q      <= KIND_END;
						byte_q      <= '0;
						len_q       <= LEN_W'(n_q);
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid   = res_valid_q;
	assign kind        = kind_q;
	assign data_byte   = byte_q;
	assign line_length = len_q;
	assign last        = last_q;

endmodule

### design/tld_checker.sv
// ----------------------------------------------------------------------------
// tld_checker: port-level checks for the terminal line discipline
// watches the character input and result ports over time
// ----------------------------------------------------------------------------
module tld_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rx_valid,
	input logic                          rx_stall,
	input logic                          res_valid,
	input logic                          res_stall,
	input logic [1:0]                    kind,
	input logic [tld_pkg::CHAR_W-1:0]    data_byte,
	input logic [tld_pkg::LEN_W-1:0]     line_length,
	input logic                          last,
	input logic                          cfg_ready
);

	import tld_pkg::*;

	// a held result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) &&
			$stable(data_byte) && $stable(line_length) && $stable(last))
		else $error("result changed while stalled");

	// a character transfer makes the input busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && !rx_stall |=> rx_stall)
		else $error("input not busy after a character transfer");

	// an end marker closes the results of its character
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_END) |-> last && (data_byte == '0))
		else $error("end marker not final or carries a byte");

	// only end markers carry a length, and no unknown kind appears
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind != KIND_END) |->
			(line_length == '0) && ((kind == KIND_ECHO) || (kind == KIND_DATA)))
		else $error("bad kind or stray line length");

	// register writes are taken only while no character is in flight
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !rx_stall)
		else $error("register port ready while a character is in flight");

endmodule

bind terminal_line_discipline tld_checker u_tld_checker (.*);
